// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file b64e_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk outside of reset.
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("checker assertion failed");

// Condition that must never be seen outside of reset.
`define CHK_NEVER(lbl, cond) `CHK_ASSERT(lbl, !(cond))

`endif

// ----- rtl/core/b64e_pkg.sv -----
package b64e_pkg;

    localparam int CharW = 8;
    localparam int SymW  = 6;
    localparam int GplW  = 6;
    localparam int CfgDataW = GplW;

    typedef enum logic [0:0] {
        CFG_WRAP_EN = 1'b0,
        CFG_GPL     = 1'b1
    } t_cfg_idx;

    localparam logic            WrapEnRst = 1'b1;
    localparam logic [GplW-1:0] GplRst    = 6'd19;

    localparam logic [CharW-1:0] ChrPad = 8'h3D;
    localparam logic [CharW-1:0] ChrCr  = 8'h0D;
    localparam logic [CharW-1:0] ChrLf  = 8'h0A;
    localparam logic [CharW-1:0] ChrUpA = 8'h41;
    localparam logic [CharW-1:0] ChrLoA = 8'h61;
    localparam logic [CharW-1:0] Chr0   = 8'h30;
    localparam logic [CharW-1:0] ChrPls = 8'h2B;
    localparam logic [CharW-1:0] ChrSls = 8'h2F;
    localparam logic [CharW-1:0] ChrLoZ = 8'h7A;
    localparam logic [CharW-1:0] ChrUpZ = 8'h5A;
    localparam logic [CharW-1:0] Chr9   = 8'h39;

    // Bytes already taken in the current three-byte group.
    localparam logic [1:0] PosFirst  = 2'd0;
    localparam logic [1:0] PosSecond = 2'd1;
    localparam logic [1:0] PosThird  = 2'd2;

    typedef struct packed {
        logic [1:0]      pos;
        logic [3:0]      held;
        logic [GplW-1:0] line_groups;
    } t_enc_state;

    // Characters caused by one input byte; lst is the index of the last one.
    typedef struct packed {
        logic [3:0][CharW-1:0] chars;
        logic [1:0]            lst;
    } t_bundle;

    function automatic logic [CharW-1:0] sym(input logic [SymW-1:0] v);
        logic [CharW-1:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            sym = ChrUpA + w;
        end else if (v < 6'd52) begin
            sym = ChrLoA + w - 8'd26;
        end else if (v < 6'd62) begin
            sym = Chr0 + w - 8'd52;
        end else if (v == 6'd62) begin
            sym = ChrPls;
        end else begin
            sym = ChrSls;
        end
    endfunction

endpackage

// ----- rtl/core/b64e_expand.sv -----
module b64e_expand (
    input  logic [7:0]                 i_byte,
    input  logic                       i_last,
    input  logic                       i_wrap_en,
    input  logic [b64e_pkg::GplW-1:0]  i_gpl,
    input  b64e_pkg::t_enc_state       i_state,
    output b64e_pkg::t_enc_state       o_state,
    output b64e_pkg::t_bundle          o_bundle
);
    import b64e_pkg::*;

    logic w_line_full;

    assign w_line_full = i_wrap_en &&
        (({1'b0, i_state.line_groups} + 7'd1) >= {1'b0, i_gpl});

    always_comb begin
        o_state  = i_state;
        o_bundle = '0;
        unique case (i_state.pos)
            PosSecond: begin
                o_bundle.chars[0] = sym({i_state.held[1:0], i_byte[7:4]});
                o_bundle.lst      = 2'd0;
                o_state.held      = i_byte[3:0];
                o_state.pos       = PosThird;
                if (i_last) begin
                    o_bundle.chars[1] = sym({i_byte[3:0], 2'b00});
                    o_bundle.chars[2] = ChrPad;
                    o_bundle.lst      = 2'd2;
                end
            end
            PosThird: begin
                o_bundle.chars[0] = sym({i_state.held, i_byte[7:6]});
                o_bundle.chars[1] = sym(i_byte[5:0]);
                o_state.held      = 4'd0;
                o_state.pos       = PosFirst;
                if (w_line_full) begin
                    o_bundle.chars[2]   = ChrCr;
                    o_bundle.chars[3]   = ChrLf;
                    o_bundle.lst        = 2'd3;
                    o_state.line_groups = '0;
                end else begin
                    o_bundle.lst        = 2'd1;
                    o_state.line_groups = i_state.line_groups + 6'd1;
                end
            end
            default: begin
                // The unused position code behaves as the start of a group.
                o_bundle.chars[0] = sym(i_byte[7:2]);
                o_bundle.lst      = 2'd0;
                o_state.held      = {2'b00, i_byte[1:0]};
                o_state.pos       = PosSecond;
                if (i_last) begin
                    o_bundle.chars[1] = sym({i_byte[1:0], 4'b0000});
                    o_bundle.chars[2] = ChrPad;
                    o_bundle.chars[3] = ChrPad;
                    o_bundle.lst      = 2'd3;
                end
            end
        endcase
        if (i_last) begin
            o_state = '0;
        end
    end

endmodule

// ----- rtl/core/base64_encoder_line_wrap.sv -----
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall | i_data_byte, i_last_byte
// output  | out       | o_out_valid / i_out_stall | o_out_char, o_out_last
// config  | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// A byte is expanded into one to four characters in the cycle it is accepted and
// held in a character buffer; the output register sends one character per cycle
// while the output is not stalled. A byte therefore occupies the output for each
// of its characters in turn, and the next byte enters while the last character of
// the previous one moves to the output register.
// Reset (synchronous, active low) clears the group state and restores the registers.
// A stall on the output holds the output register and, once the buffer is full,
// stalls the input.
module base64_encoder_line_wrap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  b64e_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [b64e_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [b64e_pkg::CharW-1:0]         o_out_char,
    output logic                               o_out_last
);
    import b64e_pkg::*;

    logic            r_wrap_en;
    logic [GplW-1:0] r_gpl;
    t_enc_state      r_state;
    t_enc_state      n_state;
    t_bundle         r_bnd;
    t_bundle         n_bnd;
    logic            r_bnd_valid;
    logic [1:0]      r_bnd_idx;
    logic            r_out_valid;
    logic [CharW-1:0] r_out_char;
    logic            r_out_last;

    logic w_load;
    logic w_bnd_done;
    logic w_in_acc;

    b64e_expand u_expand (
        .i_byte    (i_data_byte),
        .i_last    (i_last_byte),
        .i_wrap_en (r_wrap_en),
        .i_gpl     (r_gpl),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_bundle  (n_bnd)
    );

    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_bnd_done = w_load && r_bnd_valid && (r_bnd_idx == r_bnd.lst);
    assign o_in_stall = r_bnd_valid && !w_bnd_done;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_en   <= WrapEnRst;
            r_gpl       <= GplRst;
            r_state     <= '0;
            r_bnd_valid <= 1'b0;
            r_bnd_idx   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WRAP_EN: r_wrap_en <= i_cfg_data[0];
                    CFG_GPL:     r_gpl     <= i_cfg_data[GplW-1:0];
                    default:     r_gpl     <= r_gpl;
                endcase
            end
            if (w_load) begin
                r_out_valid <= r_bnd_valid;
            end
            if (w_in_acc) begin
                r_state     <= n_state;
                r_bnd_valid <= 1'b1;
                r_bnd_idx   <= 2'd0;
            end else if (w_bnd_done) begin
                r_bnd_valid <= 1'b0;
            end else if (w_load && r_bnd_valid) begin
                r_bnd_idx <= r_bnd_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_bnd <= n_bnd;
        end
        if (w_load && r_bnd_valid) begin
            r_out_char <= r_bnd.chars[r_bnd_idx];
            r_out_last <= (r_bnd_idx == r_bnd.lst);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ----- rtl/core/b64e_checker.sv -----
`include "assert_macros.svh"

module b64e_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [b64e_pkg::CharW-1:0] o_out_char,
    input logic                       o_out_last
);
    import b64e_pkg::*;

    logic w_legal;

    assign w_legal = (o_out_char >= ChrUpA && o_out_char <= ChrUpZ) ||
                     (o_out_char >= ChrLoA && o_out_char <= ChrLoZ) ||
                     (o_out_char >= Chr0 && o_out_char <= Chr9) ||
                     o_out_char == ChrPls || o_out_char == ChrSls ||
                     o_out_char == ChrPad || o_out_char == ChrCr ||
                     o_out_char == ChrLf;

    // A stalled result keeps its request and payload.
    `CHK_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char) && $stable(o_out_last))
    `CHK_NEVER(a_char_legal, o_out_valid && !w_legal)
    // A line break always closes the characters of its byte.
    `CHK_NEVER(a_lf_last, o_out_valid && o_out_char == ChrLf && !o_out_last)
    `CHK_ASSERT(a_cr_lf, o_out_valid && !i_out_stall && o_out_char == ChrCr |=> o_out_valid && o_out_char == ChrLf)

endmodule

bind base64_encoder_line_wrap b64e_checker u_b64e_checker (.*);

// ----- bench/base64_stream_check.sv -----
module base64_stream_check
    import b64e_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  t_cfg_idx            i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [CharW-1:0]    i_out_char,
    input  logic                i_out_last,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [511:0] Base64Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             last;
    } t_char_exp;

    t_char_exp expected_chars [$];

    // Encoder state and register copies kept by the checker.
    logic            wrap_on;
    logic [GplW-1:0] line_limit;
    logic [1:0]      enc_pos;
    logic [3:0]      enc_held;
    logic [GplW-1:0] enc_lines;

    function automatic logic [CharW-1:0] b64_symbol(input logic [5:0] v);
        return Base64Alphabet[8 * (63 - int'(v)) +: 8];
    endfunction

    // Works out the characters one accepted request produces and queues them.
    task automatic encode_byte(input logic [7:0] b, input logic is_last);
        logic [CharW-1:0] produced [$];
        case (enc_pos)
            PosSecond: begin
                produced.push_back(b64_symbol({enc_held[1:0], b[7:4]}));
                enc_held = b[3:0];
                enc_pos  = PosThird;
                if (is_last) begin
                    produced.push_back(b64_symbol({b[3:0], 2'b00}));
                    produced.push_back(ChrPad);
                end
            end
            PosThird: begin
                produced.push_back(b64_symbol({enc_held, b[7:6]}));
                produced.push_back(b64_symbol(b[5:0]));
                enc_held = 4'd0;
                enc_pos  = PosFirst;
                if (wrap_on && ({1'b0, enc_lines} + 7'd1 >= {1'b0, line_limit})) begin
                    produced.push_back(ChrCr);
                    produced.push_back(ChrLf);
                    enc_lines = '0;
                end else begin
                    enc_lines = enc_lines + 1'b1;
                end
            end
            default: begin
                produced.push_back(b64_symbol(b[7:2]));
                enc_held = {2'b00, b[1:0]};
                enc_pos  = PosSecond;
                if (is_last) begin
                    produced.push_back(b64_symbol({b[1:0], 4'b0000}));
                    produced.push_back(ChrPad);
                    produced.push_back(ChrPad);
                end
            end
        endcase
        foreach (produced[k]) begin
            expected_chars.push_back('{ch: produced[k], last: (k == produced.size() - 1)});
        end
        if (is_last) begin
            enc_pos   = PosFirst;
            enc_held  = 4'd0;
            enc_lines = '0;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : monitor
        t_char_exp head;
        if (!i_rst_n) begin
            expected_chars.delete();
            wrap_on    = WrapEnRst;
            line_limit = GplRst;
            enc_pos    = PosFirst;
            enc_held   = 4'd0;
            enc_lines  = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WRAP_EN: wrap_on = i_cfg_data[0];
                    CFG_GPL:     line_limit = i_cfg_data[GplW-1:0];
                    default:     ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_data_byte, i_last_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected character 0x%02h (last %0b), nothing expected",
                             $time, i_out_char, i_out_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    head = expected_chars.pop_front();
                    if (head.ch !== i_out_char || head.last !== i_out_last) begin
                        $display("%0t: mismatch, expected char 0x%02h last %0b, got 0x%02h last %0b",
                                 $time, head.ch, head.last, i_out_char, i_out_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

// ----- bench/base64_encoder_line_wrap_test.sv -----
module base64_encoder_line_wrap_test;
    import b64e_pkg::*;

    localparam int LongHoldCycles = 150;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    t_cfg_idx            cfg_idx;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                out_valid;
    logic                out_stall;
    logic [CharW-1:0]    out_char;
    logic                out_last;
    int                  fail_count;
    int                  pending_chars;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit                  hold_req = 1'b0;
    int                  burst_left = 1;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    base64_encoder_line_wrap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_data_byte (data_byte),
        .i_last_byte (last_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_char  (out_char),
        .o_out_last  (out_last)
    );

    base64_stream_check checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_last_byte  (last_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_char   (out_char),
        .i_out_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one request and returns once it is taken; bursts end in a random gap.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_message(input int len, input bit finish);
        for (int k = 0; k < len; k++) begin
            send_byte(random_byte(), finish && (k == len - 1));
        end
    endtask

    task automatic send_messages(input int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
            send_message(len, 1'b1);
            sent += len;
        end
    endtask

    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_chars != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Receiver: alternates between stall patterns, plus one long hold-off on request.
    initial begin
        int mode;
        int len;
        out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (LongHoldCycles) begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(5, 60);
                for (int c = 0; c < len; c++) begin
                    @(negedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 2) == 0);
                        2:       out_stall <= (c % 3 == 2);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_WRAP_EN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        last_byte = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // One-byte and two-byte messages need padding; then a full final group.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);
        // These three bytes map onto the two symbols at the top of the alphabet.
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        drain_output();

        // One group per line, so every group is followed by a line break.
        write_reg(CFG_GPL, 6'd1);
        send_message(6, 1'b1);
        drain_output();
        write_reg(CFG_GPL, 6'd0);
        send_message(3, 1'b1);
        drain_output();

        // Shorten the line in the middle of a message: the next group wraps.
        write_reg(CFG_GPL, 6'd19);
        send_message(9, 1'b0);
        drain_output();
        write_reg(CFG_GPL, 6'd2);
        send_message(3, 1'b1);
        drain_output();

        // Short lines, with one long hold-off at the output while requests keep coming.
        write_reg(CFG_WRAP_EN, 6'd1);
        write_reg(CFG_GPL, 6'($urandom_range(2, 6)));
        hold_req = 1'b1;
        wait (hold_req == 1'b0);
        send_messages(10);
        drain_output();

        // With wrapping off the group count rolls over after 64 groups; 66 groups
        // leave it at two, which decides where the first break falls afterwards.
        write_reg(CFG_WRAP_EN, 6'd0);
        write_reg(CFG_GPL, 6'd63);
        send_message(198, 1'b0);
        drain_output();
        write_reg(CFG_WRAP_EN, 6'd1);
        write_reg(CFG_GPL, 6'd5);
        send_message(12, 1'b1);
        drain_output();

        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3200000;
        $display("Some tests failed");
        $finish;
    end

endmodule
